>>> rtl/pixel_colour_adjust_unit_assert.svh
// Assertion macros used by the checker of the pixel colour adjust unit.
`ifndef PIXEL_COLOUR_ADJUST_UNIT_ASSERT_SVH
`define PIXEL_COLOUR_ADJUST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("pixel colour adjust assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("pixel colour adjust assertion failed");

`endif

>>> rtl/pca_pkg.sv
// Package with the types and constants of the pixel colour adjust unit.
`default_nettype none

package pca_pkg;

  typedef enum logic [2:0] {
    MODE_INVERT    = 3'd0,
    MODE_BRIGHTEN  = 3'd1,
    MODE_DARKEN    = 3'd2,
    MODE_CONTRAST  = 3'd3,
    MODE_THRESHOLD = 3'd4,
    MODE_SEPIA     = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_STEP = 2'd1,
    REG_GAIN = 2'd2
  } reg_e;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned GainW  = 12;
  localparam int unsigned CProdW = ChanW + GainW;
  localparam int unsigned SProdW = 18;
  localparam int unsigned SSumW  = 19;

  localparam logic [GainW-1:0] GainReset = 12'd256;

  // Sepia coefficients in Q0.10, one row per output channel.
  localparam logic [9:0] SEPIA_K [3][3] = '{
    '{10'd402, 10'd787, 10'd194},
    '{10'd357, 10'd702, 10'd172},
    '{10'd279, 10'd547, 10'd134}
  };

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       last_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       last_out;
  } result_t;

  typedef struct packed {
    mode_e             mode;
    logic [ChanW-1:0]  brightness_step;
    logic [GainW-1:0]  contrast_gain;
  } cfg_t;

  typedef struct packed {
    logic                             last;
    logic [2:0][ChanW-1:0]            simple;
    logic [2:0][CProdW-1:0]           cprod;
    logic [2:0][2:0][SProdW-1:0]      sprod;
  } stage1_t;

  typedef struct packed {
    logic                  last;
    logic [2:0][ChanW-1:0] simple;
    logic [2:0][ChanW-1:0] contrast;
    logic [2:0][SSumW-1:0] sepsum;
  } stage2_t;

endpackage

`default_nettype wire

>>> rtl/pixel_colour_adjust_unit.sv
// Top level of the pixel colour adjust unit: register port and three-stage pipeline.
//
// Usage: a pixel beat is taken on pixel_i at each rising edge where start is
// high and busy is low. busy is held low, so one pixel can enter every cycle.
// The adjusted pixel appears on result_o with done_o high for exactly one
// cycle, after passing each stage register in turn; throughput is one pixel
// per cycle. The stages are the channel multipliers, the contrast and sepia
// adders, and the final clamp and mode select feeding the result register.
// The receiver cannot stall, so every result is shown once and is gone the
// next cycle. The mode, brightness step and contrast gain registers are written over
// the APB-style port at byte addresses 0, 4 and 8; the user must write them only while
// no pixel is in flight, which the block does not enforce. Reset clears the pipeline
// valid bits and loads mode invert, a step of zero and a unity contrast gain.
`default_nettype none

module pixel_colour_adjust_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [3:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  wire logic            start,
  output logic                 busy,
  input  wire pca_pkg::pixel_t pixel_i,
  output logic                 done_o,
  output pca_pkg::result_t     result_o
);

  pca_pkg::cfg_t    cfg;
  pca_pkg::stage1_t s1;
  pca_pkg::stage2_t s2;
  logic             s1_valid;
  logic             s2_valid;

  assign busy = 1'b0;

  pca_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pca_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .pixel_i (pixel_i),
    .cfg_i   (cfg),
    .valid_o (s1_valid),
    .s1_o    (s1)
  );

  pca_sum_stage u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .s1_i    (s1),
    .gain_i  (cfg.contrast_gain),
    .valid_o (s2_valid),
    .s2_o    (s2)
  );

  pca_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .s2_i     (s2),
    .mode_i   (cfg.mode),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

>>> rtl/pca_regs.sv
// Configuration register file with its APB-style access port.
`default_nettype none

module pca_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pca_pkg::cfg_t      cfg_o
);

  pca_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  pca_pkg::reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = pca_pkg::reg_e'(paddr[3:2]);
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        pca_pkg::REG_MODE: cfg_d.mode = pca_pkg::mode_e'(pwdata[2:0]);
        pca_pkg::REG_STEP: cfg_d.brightness_step = pwdata[pca_pkg::ChanW-1:0];
        pca_pkg::REG_GAIN: cfg_d.contrast_gain = pwdata[pca_pkg::GainW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pca_pkg::REG_MODE: prdata = {29'd0, cfg_q.mode};
      pca_pkg::REG_STEP: prdata = {24'd0, cfg_q.brightness_step};
      pca_pkg::REG_GAIN: prdata = {20'd0, cfg_q.contrast_gain};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= pca_pkg::MODE_INVERT;
      cfg_q.brightness_step <= '0;
      cfg_q.contrast_gain   <= pca_pkg::GainReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pca_mul_stage.sv
// First pipeline stage: simple point operations and all channel products.
`default_nettype none

module pca_mul_stage (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire pca_pkg::pixel_t pixel_i,
  input  wire pca_pkg::cfg_t   cfg_i,
  output logic                 valid_o,
  output pca_pkg::stage1_t     s1_o
);

  logic [2:0][7:0]  ch;
  logic             dark;
  pca_pkg::stage1_t s1_d, s1_q;
  logic             valid_q;
  logic [8:0]       bright_sum [3];

  assign ch[0] = pixel_i.red_in;
  assign ch[1] = pixel_i.green_in;
  assign ch[2] = pixel_i.blue_in;
  assign dark  = !ch[0][7] || !ch[1][7] || !ch[2][7];

  always_comb begin
    s1_d.last = pixel_i.last_in;
    for (int i = 0; i < 3; i++) begin
      bright_sum[i] = {1'b0, ch[i]} + {1'b0, cfg_i.brightness_step};
      case (cfg_i.mode)
        pca_pkg::MODE_INVERT:    s1_d.simple[i] = 8'hFF - ch[i];
        pca_pkg::MODE_BRIGHTEN:  s1_d.simple[i] = bright_sum[i][8] ? 8'hFF
                                                                     : bright_sum[i][7:0];
        pca_pkg::MODE_DARKEN:    s1_d.simple[i] = (ch[i] > cfg_i.brightness_step)
                                                  ? ch[i] - cfg_i.brightness_step : 8'd0;
        pca_pkg::MODE_THRESHOLD: s1_d.simple[i] = dark ? 8'h00 : 8'hFF;
        default:                 s1_d.simple[i] = ch[i];
      endcase
      s1_d.cprod[i] = pca_pkg::CProdW'(cfg_i.contrast_gain) * pca_pkg::CProdW'(ch[i]);
      for (int k = 0; k < 3; k++) begin
        s1_d.sprod[i][k] = pca_pkg::SProdW'(pca_pkg::SEPIA_K[i][k])
                           * pca_pkg::SProdW'(ch[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_q <= s1_d;
    end
  end

  assign valid_o = valid_q;
  assign s1_o    = s1_q;

endmodule

`default_nettype wire

>>> rtl/pca_sum_stage.sv
// Second pipeline stage: contrast offset and clamp, sepia sums.
`default_nettype none

module pca_sum_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  input  wire pca_pkg::stage1_t             s1_i,
  input  wire logic [pca_pkg::GainW-1:0]    gain_i,
  output logic                              valid_o,
  output pca_pkg::stage2_t                  s2_o
);

  pca_pkg::stage2_t s2_d, s2_q;
  logic             valid_q;
  logic [20:0]      pos  [3];
  logic [20:0]      neg;
  logic [20:0]      diff [3];

  assign neg = 21'({gain_i, 7'd0});

  always_comb begin
    s2_d.last   = s1_i.last;
    s2_d.simple = s1_i.simple;
    for (int i = 0; i < 3; i++) begin
      pos[i]  = 21'(s1_i.cprod[i]) + 21'd32768;
      diff[i] = pos[i] - neg;
      if (pos[i] < neg) begin
        s2_d.contrast[i] = 8'd0;
      end else if (|diff[i][20:16]) begin
        s2_d.contrast[i] = 8'hFF;
      end else begin
        s2_d.contrast[i] = diff[i][15:8];
      end
      s2_d.sepsum[i] = pca_pkg::SSumW'(s1_i.sprod[i][0])
                     + pca_pkg::SSumW'(s1_i.sprod[i][1])
                     + pca_pkg::SSumW'(s1_i.sprod[i][2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = valid_q;
  assign s2_o    = s2_q;

endmodule

`default_nettype wire

>>> rtl/pca_out_stage.sv
// Third pipeline stage: sepia scaling and clamp, mode select, result register.
`default_nettype none

module pca_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire pca_pkg::stage2_t s2_i,
  input  wire pca_pkg::mode_e   mode_i,
  output logic                  done_o,
  output pca_pkg::result_t      result_o
);

  logic [2:0][7:0]  chan;
  logic [8:0]       sep [3];
  pca_pkg::result_t res_d, res_q;
  logic             done_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sep[i] = s2_i.sepsum[i][18:10];
      case (mode_i)
        pca_pkg::MODE_CONTRAST: chan[i] = s2_i.contrast[i];
        pca_pkg::MODE_SEPIA:    chan[i] = sep[i][8] ? 8'hFF : sep[i][7:0];
        default:                chan[i] = s2_i.simple[i];
      endcase
    end
    res_d.red_out   = chan[0];
    res_d.green_out = chan[1];
    res_d.blue_out  = chan[2];
    res_d.last_out  = s2_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

>>> rtl/pca_checker.sv
// Port-level assertion checker for the pixel colour adjust unit, with its bind.
`default_nettype none

`include "pixel_colour_adjust_unit_assert.svh"

module pca_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire pca_pkg::pixel_t  pixel_i,
  input wire logic             done_o,
  input wire pca_pkg::result_t result_o
);

  logic       take;
  logic [2:0] take_hist_q;

  assign take = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_hist_q <= '0;
    end else begin
      take_hist_q <= {take_hist_q[1:0], take};
    end
  end

  `PCA_ASSERT_IMPL(a_never_busy, clk_i, rst_ni, 1'b1, !busy)

  `PCA_ASSERT_IMPL(a_done_has_beat, clk_i, rst_ni, done_o, $past(take, 3))

  `PCA_ASSERT_IMPL(a_beat_gives_done, clk_i, rst_ni, take_hist_q[2], done_o)

  `PCA_ASSERT_IMPL(a_last_follows, clk_i, rst_ni, done_o, result_o.last_out == $past(pixel_i.last_in, 3))

endmodule

bind pixel_colour_adjust_unit pca_checker u_pca_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .pixel_i  (pixel_i),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for the pixel colour adjust unit: register settings, pixels, scoreboard.
`timescale 1ns / 100ps

import pca_pkg::*;

class colour_scoreboard;
  logic [2:0]  mode_q;
  logic [7:0]  step_q;
  logic [11:0] gain_q;
  result_t     pending[$];
  int          mismatches;
  int          checked;

  function new();
    mode_q     = MODE_INVERT;
    step_q     = 8'd0;
    gain_q     = GainReset;
    mismatches = 0;
    checked    = 0;
  endfunction

  function int clip(int v);
    return (v > 255) ? 255 : v;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] data);
    case (idx)
      REG_MODE: mode_q = data[2:0];
      REG_STEP: step_q = data[7:0];
      REG_GAIN: gain_q = data[11:0];
      default: ;
    endcase
  endfunction

  function void note_pixel(pixel_t px);
    int      chan[3];
    int      adj[3];
    int      g;
    int      stp;
    int      pos;
    int      neg;
    bit      dark;
    result_t res;
    chan[0] = px.red_in;
    chan[1] = px.green_in;
    chan[2] = px.blue_in;
    g       = gain_q;
    stp     = step_q;
    case (mode_q)
      MODE_INVERT: begin
        foreach (adj[i]) adj[i] = 255 - chan[i];
      end
      MODE_BRIGHTEN: begin
        foreach (adj[i]) adj[i] = clip(chan[i] + stp);
      end
      MODE_DARKEN: begin
        foreach (adj[i]) adj[i] = (chan[i] > stp) ? chan[i] - stp : 0;
      end
      MODE_CONTRAST: begin
        foreach (adj[i]) begin
          pos    = g * chan[i] + 32768;
          neg    = g * 128;
          adj[i] = (pos < neg) ? 0 : clip((pos - neg) >> 8);
        end
      end
      MODE_THRESHOLD: begin
        dark = (chan[0] <= 127) || (chan[1] <= 127) || (chan[2] <= 127);
        foreach (adj[i]) adj[i] = dark ? 0 : 255;
      end
      MODE_SEPIA: begin
        adj[0] = clip((402 * chan[0] + 787 * chan[1] + 194 * chan[2]) >> 10);
        adj[1] = clip((357 * chan[0] + 702 * chan[1] + 172 * chan[2]) >> 10);
        adj[2] = clip((279 * chan[0] + 547 * chan[1] + 134 * chan[2]) >> 10);
      end
      default: begin
        foreach (adj[i]) adj[i] = chan[i];
      end
    endcase
    res.red_out   = 8'(adj[0]);
    res.green_out = 8'(adj[1]);
    res.blue_out  = 8'(adj[2]);
    res.last_out  = px.last_in;
    pending.push_back(res);
  endfunction

  function void check_result(result_t got);
    result_t want;
    checked++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected result beat: r=%0d g=%0d b=%0d last=%0d",
                 got.red_out, got.green_out, got.blue_out, got.last_out);
    end else begin
      want = pending.pop_front();
      if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
          got.blue_out !== want.blue_out || got.last_out !== want.last_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                   want.red_out, want.green_out, want.blue_out, want.last_out,
                   got.red_out, got.green_out, got.blue_out, got.last_out);
      end
    end
  endfunction
endclass

module testbench;

  localparam int         IdleLimit    = 2000;
  localparam logic [1:0] RegSpare     = 2'd3;
  localparam logic [2:0] ModePassLow  = 3'd6;
  localparam logic [2:0] ModePassHigh = 3'd7;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start   = 1'b0;
  logic        busy;
  pixel_t      pixel_i = '0;
  logic        done_o;
  result_t     result_o;

  colour_scoreboard sb;
  pixel_t           corner_px[4];
  int               pixels_in;
  int               results_out;
  int               reg_writes;
  int               settings_loaded;
  int               idle_cycles;

  pixel_colour_adjust_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .busy     (busy),
    .pixel_i  (pixel_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        sb.note_pixel(pixel_i);
        pixels_in++;
      end
      if (done_o) begin
        sb.check_result(result_o);
        results_out++;
      end
      if ((start && !busy) || done_o || (psel && penable && pwrite && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired after %0d idle cycles", idle_cycles);
        $display("pixel_colour_adjust_unit verification failed");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(120, 135));
      3, 4:    return 8'($urandom_range(128, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red_in   = rand_chan();
    px.green_in = rand_chan();
    px.blue_in  = rand_chan();
    px.last_in  = ($urandom_range(0, 3) == 0);
    return px;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, data);
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [2:0] mode, input logic [7:0] step,
                               input logic [11:0] gain);
    logic [31:0] word;
    word       = $urandom;
    word[2:0]  = mode;
    apb_write(REG_MODE, word);
    word       = $urandom;
    word[7:0]  = step;
    apb_write(REG_STEP, word);
    word       = $urandom;
    word[11:0] = gain;
    apb_write(REG_GAIN, word);
    apb_write(RegSpare, $urandom);
    settings_loaded++;
  endtask

  task automatic send_pixel(input pixel_t px);
    start   <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic directed_case(input logic [2:0] mode, input logic [7:0] step,
                               input logic [11:0] gain, input int count);
    drain_results();
    load_settings(mode, step, gain);
    for (int i = 0; i < count; i++) send_pixel(corner_px[i]);
    start <= 1'b0;
  endtask

  task automatic run_pixels(input int count, input bit hold);
    int burst;
    int gap;
    burst = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_pixel());
      burst--;
      if (hold && i == count / 2) begin
        start <= 1'b0;
        drain_results();
        burst = $urandom_range(1, 16);
      end else if (burst == 0) begin
        burst = $urandom_range(1, 16);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    logic [7:0]  step;
    logic [11:0] gain;
    sb              = new();
    pixels_in       = 0;
    results_out     = 0;
    reg_writes      = 0;
    settings_loaded = 0;
    idle_cycles     = 0;
    corner_px[0] = '{red_in: 8'd0,   green_in: 8'd0,   blue_in: 8'd0,   last_in: 1'b0};
    corner_px[1] = '{red_in: 8'd255, green_in: 8'd255, blue_in: 8'd255, last_in: 1'b1};
    corner_px[2] = '{red_in: 8'd128, green_in: 8'd128, blue_in: 8'd128, last_in: 1'b0};
    corner_px[3] = '{red_in: 8'd127, green_in: 8'd255, blue_in: 8'd255, last_in: 1'b1};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int i = 0; i < 4; i++) send_pixel(corner_px[i]);
    start <= 1'b0;
    directed_case(MODE_BRIGHTEN,  8'd255, GainReset, 2);
    directed_case(MODE_DARKEN,    8'd255, GainReset, 2);
    directed_case(MODE_CONTRAST,  8'd0,   12'd4095,  3);
    directed_case(MODE_CONTRAST,  8'd0,   12'd0,     1);
    directed_case(MODE_THRESHOLD, 8'd0,   GainReset, 4);
    directed_case(MODE_SEPIA,     8'd0,   GainReset, 3);
    directed_case(ModePassLow,    8'd17,  12'd100,   2);
    directed_case(ModePassHigh,   8'd200, 12'd3000,  2);

    for (int ph = 0; ph < 16; ph++) begin
      case ($urandom_range(0, 3))
        0:       step = 8'd0;
        1:       step = 8'd255;
        default: step = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0:       gain = 12'd0;
        1:       gain = 12'd4095;
        2:       gain = GainReset;
        3:       gain = 12'($urandom_range(0, 511));
        default: gain = 12'($urandom_range(0, 4095));
      endcase
      drain_results();
      load_settings(3'(ph % 8), step, gain);
      run_pixels(30, (ph % 3) == 0);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d pixels and %0d result beats over %0d register settings",
             pixels_in, results_out, settings_loaded);
    $display("All eight mode codes, step and gain extremes, %0d register writes, %0d mismatches",
             reg_writes, sb.mismatches);
    if (sb.pending.size() != 0)
      $display("%0d expected result beats never arrived", sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("pixel_colour_adjust_unit verification clean");
    else
      $display("pixel_colour_adjust_unit verification failed");
    $finish;
  end

endmodule
